// ===== design/ecss_pkg.sv =====
// Shared types, constants and decode functions for the encoder counter display scan.
`default_nettype none
package ecss_pkg;

	localparam int COUNT_W = 14;
	localparam int SEG_W   = 7;
	localparam int EN_W    = 4;
	localparam int POS_W   = 2;
	localparam int RECIP_W = 24;
	localparam int RECIP_SH = 23;
	localparam int QUOT_W  = 14;
	localparam int DIV10_W = 16;
	localparam int DIV10_SH = 19;

	localparam logic [COUNT_W-1:0] COUNT_TOP_RESET = 14'd4095;
	localparam logic [DIV10_W-1:0] DIV10_RECIP     = 16'd52429;
	localparam logic [POS_W-1:0]   POS_THOUSANDS   = 2'd3;
	localparam logic [EN_W-1:0]    EN_ALL_OFF      = 4'hF;
	localparam logic [EN_W-1:0]    EN_UNITS        = 4'b1000;

	typedef enum logic [1:0] {
		OP_STEP    = 2'd0,
		OP_BUTTON  = 2'd1,
		OP_REFRESH = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       clock_level;
		logic       data_level;
	} item_t;

	typedef struct packed {
		logic               refresh;
		logic [POS_W-1:0]   pos;
		logic [COUNT_W-1:0] count;
		logic [QUOT_W-1:0]  quot;
	} digit_req_t;

	// Scaled reciprocal of 1, 10, 100, 1000 for a 14-bit dividend.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [POS_W-1:0] pos);
		logic [RECIP_W-1:0] r;
		case (pos)
			2'd0:    r = 24'd8388608;
			2'd1:    r = 24'd838861;
			2'd2:    r = 24'd83887;
			default: r = 24'd8389;
		endcase
		return r;
	endfunction

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== design/ecss_count_stage.sv =====
// Count update, scan position and digit quotient stage.
`default_nettype none
module ecss_count_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write_en,
	input  wire logic [ecss_pkg::COUNT_W-1:0] cfg_write_data,
	input  wire logic                        advance,
	input  wire ecss_pkg::item_t             item_s1,
	output      ecss_pkg::digit_req_t        req_s2
);
	import ecss_pkg::*;

	logic [COUNT_W-1:0] count_top_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   scan_q;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W+RECIP_W-1:0] prod;
	logic               is_refresh;

	always_comb begin
		count_next = count_q;
		is_refresh = 1'b0;
		case (item_s1.operation)
			OP_STEP: begin
				if (item_s1.clock_level != item_s1.data_level) begin
					if (count_q >= count_top_q)
						count_next = '0;
					else
						count_next = count_q + 14'd1;
				end else begin
					if (count_q == '0)
						count_next = count_top_q;
					else
						count_next = count_q - 14'd1;
				end
			end
			OP_BUTTON: count_next = '0;
			OP_REFRESH: is_refresh = 1'b1;
			default: count_next = count_q;
		endcase
	end

	assign prod = (COUNT_W+RECIP_W)'(count_q) * (COUNT_W+RECIP_W)'(recip_of(scan_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_top_q <= COUNT_TOP_RESET;
			count_q     <= '0;
			scan_q      <= '0;
		end else begin
			if (cfg_write_en)
				count_top_q <= cfg_write_data;
			if (advance) begin
				count_q <= count_next;
				if (is_refresh)
					scan_q <= scan_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_s2.refresh <= is_refresh;
			req_s2.pos     <= scan_q;
			req_s2.count   <= count_next;
			req_s2.quot    <= prod[RECIP_SH+QUOT_W-1:RECIP_SH];
		end
	end

endmodule
`default_nettype wire

// ===== design/ecss_digit_stage.sv =====
// Decimal digit, segment decode and held display outputs.
`default_nettype none
module ecss_digit_stage (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire ecss_pkg::digit_req_t         req_s2,
	output      logic [ecss_pkg::COUNT_W-1:0] count_s3,
	output      logic [ecss_pkg::SEG_W-1:0]   seg_s3,
	output      logic [ecss_pkg::EN_W-1:0]    en_s3
);
	import ecss_pkg::*;

	logic [SEG_W-1:0] seg_q;
	logic [EN_W-1:0]  en_q;
	logic [QUOT_W+DIV10_W-1:0] p10;
	logic [QUOT_W-1:0] q10;
	logic [QUOT_W-1:0] rem;
	logic [3:0]        digit;
	logic [SEG_W-1:0]  seg_new;
	logic [EN_W-1:0]   en_new;

	assign p10 = (QUOT_W+DIV10_W)'(req_s2.quot) * (QUOT_W+DIV10_W)'(DIV10_RECIP);
	assign q10 = QUOT_W'(p10[QUOT_W+DIV10_W-1:DIV10_SH]);
	assign rem = req_s2.quot - (q10 << 3) - (q10 << 1);

	always_comb begin
		if (req_s2.pos == POS_THOUSANDS) begin
			digit   = req_s2.quot[3:0];
			seg_new = (req_s2.quot < 14'd10) ? seg_of(digit) : '0;
		end else begin
			digit   = rem[3:0];
			seg_new = seg_of(digit);
		end
		en_new = ~(EN_UNITS >> req_s2.pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			en_q  <= EN_ALL_OFF;
		end else if (advance && req_s2.refresh) begin
			seg_q <= seg_new;
			en_q  <= en_new;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_s3 <= req_s2.count;
			seg_s3   <= req_s2.refresh ? seg_new : seg_q;
			en_s3    <= req_s2.refresh ? en_new : en_q;
		end
	end

endmodule
`default_nettype wire

// ===== design/encoder_counter_seven_segment_scan_top.sv =====
// Top level of the encoder counter with four-digit multiplexed display scan.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid / in_ready    | operation, clock_level, data_level
//  out     | output    | out_valid / out_ready  | count_value, segments, digit_enables
//  cfg     | input     | cfg_write_en           | cfg_write_data (count_top)
//
// One item per cycle sustained while the output is not stalled; each item's result passes the
// input register at its accepting edge, then the count and quotient stage, then the digit and
// output register. Reset clears the count and scan position, turns the held segment and enable
// registers off (the output registers are not reset) and loads count_top with 4095. A stalled
// output holds each full stage whose following stages are all full; empty stages keep filling.
`default_nettype none
module encoder_counter_seven_segment_scan_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [ecss_pkg::COUNT_W-1:0] cfg_write_data,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [1:0]                   operation,
	input  wire logic                         clock_level,
	input  wire logic                         data_level,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic [ecss_pkg::COUNT_W-1:0] count_value,
	output      logic [ecss_pkg::SEG_W-1:0]   segments,
	output      logic [ecss_pkg::EN_W-1:0]    digit_enables
);
	import ecss_pkg::*;

	item_t      item_s1;
	digit_req_t req_s2;
	logic       v1_q, v2_q, v3_q;
	logic       r1, r2, r3;

	assign r3 = !v3_q || out_ready;
	assign r2 = !v2_q || r3;
	assign r1 = !v1_q || r2;
	assign in_ready  = r1;
	assign out_valid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (r1)
				v1_q <= in_valid;
			if (r2)
				v2_q <= v1_q;
			if (r3)
				v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && r1) begin
			item_s1.operation   <= operation;
			item_s1.clock_level <= clock_level;
			item_s1.data_level  <= data_level;
		end
	end

	ecss_count_stage u_count (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.advance        (v1_q && r2),
		.item_s1        (item_s1),
		.req_s2         (req_s2)
	);

	ecss_digit_stage u_digit (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (v2_q && r3),
		.req_s2   (req_s2),
		.count_s3 (count_value),
		.seg_s3   (segments),
		.en_s3    (digit_enables)
	);

endmodule
`default_nettype wire
